// ----- design/sha256_pkg.sv -----
`default_nettype none
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;

    // one queued item between front and back
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ----- design/sha256_front.sv -----
`default_nettype none
// input side: takes items, drops empty ones, holds a short queue for the core
module sha256_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire sha256_pkg::item_t    in_item,
    output logic                      q_valid,
    output sha256_pkg::item_t         q_item,
    input  wire logic                 q_take
);
    import sha256_pkg::*;

    item_t      slot_reg [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       put;

    // items with neither flag cause nothing and are dropped here
    assign full    = (cnt_reg == 3'd4);
    assign put     = push && !full && (in_item.byte_present || in_item.end_of_message);
    assign q_valid = (cnt_reg != 3'd0);
    assign q_item  = slot_reg[rd_reg];

    // pointer and count update
    always_comb
    begin
        wr_next  = put ? wr_reg + 2'd1 : wr_reg;
        rd_next  = (q_take && q_valid) ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'b0, put} - {2'b0, q_take && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (put)
            slot_reg[wr_reg] <= in_item;
    end
endmodule
`default_nettype wire

// ----- design/sha256_back.sv -----
`default_nettype none
// block assembly, padding, compression rounds and digest output
module sha256_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire sha256_pkg::item_t    q_item,
    output logic                      q_take,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [31:0]               digest_word,
    output logic [2:0]                word_index,
    output logic                      last_word
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_COMP  = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [5:0]    fill_reg;
    logic [63:0]   len_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic          eom_reg;
    logic          mark_reg;
    logic          skip_reg;
    logic [2:0]    oidx_reg;
    logic [31:0]   t1, t2, s0, s1, wnew, wcur;
    logic          take_byte;
    logic          shift_in;
    logic [7:0]    in_byte;
    logic          len_phase;

    assign q_take      = (state_reg == S_IDLE) && q_valid;
    assign take_byte   = q_take && q_item.byte_present;
    assign empty       = (state_reg != S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    // length bytes end the 0x80 mark's block, or the next if the mark is in its last 8
    assign len_phase = (state_reg == S_PAD) && mark_reg && !skip_reg && (fill_reg >= 6'd56);

    // byte entering the block: message byte, or 0x80, zero or length byte while padding
    always_comb
    begin
        shift_in = 1'b0;
        in_byte  = q_item.msg_byte;
        if (state_reg == S_IDLE)
            shift_in = take_byte;
        else if (state_reg == S_PAD)
        begin
            shift_in = 1'b1;
            if (!mark_reg)
                in_byte = 8'h80;
            else if (len_phase)
                in_byte = len_reg[63:56];
            else
                in_byte = 8'h00;
        end
    end

    // round datapath: schedule from a 16-word window
    always_comb
    begin
        wcur = w_reg[0];
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1   = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + wcur;
        t2   = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (q_take)
                begin
                    if (take_byte && fill_reg == 6'(BlockBytes - 1))
                        state_next = S_COMP;
                    else if (q_item.end_of_message)
                        state_next = S_PAD;
                end
            S_PAD:   if (fill_reg == 6'(BlockBytes - 1)) state_next = S_COMP;
            S_COMP:  if (rnd_reg == 6'(Rounds - 1)) state_next = S_ADD;
            S_ADD:
                if (eom_reg && mark_reg && !skip_reg) state_next = S_OUT;
                else if (eom_reg)                     state_next = S_PAD;
                else                                  state_next = S_IDLE;
            S_OUT:   if (pop && oidx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            eom_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= InitHash[255 - 32*i -: 32];
        end
        else
        begin
            state_reg <= state_next;
            if (shift_in)
                fill_reg <= fill_reg + 6'd1;
            case (state_reg)
                S_IDLE:
                    if (q_take)
                    begin
                        if (take_byte)
                            len_reg <= len_reg + 64'd8;
                        if (q_item.end_of_message)
                            eom_reg <= 1'b1;
                    end
                S_PAD:
                begin
                    // a mark too late for the length pushes it into one more block
                    if (!mark_reg)
                    begin
                        mark_reg <= 1'b1;
                        skip_reg <= (fill_reg >= 6'd56);
                    end
                    if (len_phase)
                        len_reg <= {len_reg[55:0], 8'h00};
                end
                S_COMP:    rnd_reg <= rnd_reg + 6'd1;
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    skip_reg <= 1'b0;
                end
                S_OUT:
                    if (pop)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            eom_reg  <= 1'b0;
                            mark_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= InitHash[255 - 32*i -: 32];
                        end
                    end
                default: ;
            endcase
        end
    end

    // working variables and the window, which also collects the block bytes
    always_ff @(posedge clk)
    begin
        if (state_reg != S_COMP && state_next == S_COMP)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == S_COMP)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        // bytes shift in big-endian, the first byte ends up on top of word 0
        if (shift_in)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], in_byte};
        end
        else if (state_reg == S_COMP)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
        end
    end
endmodule
`default_nettype wire

// ----- design/sha256_stream_hasher_top.sv -----
`default_nettype none
// SHA-256 over a byte stream.
// input channel: push/full with msg_byte, byte_present and end_of_message;
// an item with byte_present adds one byte, an item with end_of_message
// closes the message (its byte, if any, counts first).
// result channel: empty/pop with digest_word, word_index and last_word;
// each closed message gives eight words, index 0 first, last_word on 7.
// a four-entry queue sits between the input side and the compression core,
// so bytes are taken one per cycle while the core is free; every 64th
// byte starts 64 rounds (one per cycle) and an add step, during which
// the queue fills and full rises.
// closing a message shifts the padding in one byte per cycle up to the end
// of the block and runs one or two compressions before the first word is
// ready; the words then wait until popped; a stalled receiver holds the
// core, and input stalls once the queue is full.
// reset clears the queue and loads the initial hash values.
module sha256_stream_hasher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha256_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_take;

    assign in_item = '{msg_byte: msg_byte, byte_present: byte_present,
                       end_of_message: end_of_message};

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
    );

    sha256_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );
endmodule
`default_nettype wire
